@@ sv/periodic_task_dispatcher_assert.svh @@
`ifndef PERIODIC_TASK_DISPATCHER_ASSERT_SVH
`define PERIODIC_TASK_DISPATCHER_ASSERT_SVH

// same-cycle implication
`define PTD_ASSERT_SAME(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("ptd assertion failed");

// next-cycle implication
`define PTD_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("ptd assertion failed");

`endif

@@ sv/ptd_pkg.sv @@
package ptd_pkg;

   localparam int NUM_TASKS = 16;
   localparam int SLOT_W    = $clog2(NUM_TASKS);
   localparam int CNT_W     = $clog2(NUM_TASKS + 1);
   localparam int ID_COUNT  = 16;
   localparam int ID_W      = 4;
   localparam int TIME_W    = 32;

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [ID_W-1:0]   task_id_type;
   typedef logic [TIME_W-1:0] time_type;

   localparam logic [1:0] OP_POLL       = 2'd0;
   localparam logic [1:0] OP_ADD        = 2'd1;
   localparam logic [1:0] OP_SET_ENABLE = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

   // one write per cycle into the slot table
   typedef struct packed {
      logic        wr_en;
      slot_type    slot;
      logic        cfg_en;     // period and task id
      time_type    period;
      task_id_type task_id;
      logic        enable_en;
      logic        enable;
      time_type    last_time;  // written on every wr_en
   } slot_write_type;

   typedef struct packed {
      time_type    period;
      logic        enable;
      time_type    last_time;
      task_id_type task_id;
   } slot_read_type;

endpackage

@@ sv/ptd_slot_table.sv @@
module ptd_slot_table (
   input  logic                    clock,
   input  ptd_pkg::slot_write_type wr,
   input  ptd_pkg::slot_type       rd_slot,
   output ptd_pkg::slot_read_type  rd
);

   // entries are only read below the fill count, so they need no reset
   ptd_pkg::time_type    period_ff    [ptd_pkg::NUM_TASKS];
   logic                 enable_ff    [ptd_pkg::NUM_TASKS];
   ptd_pkg::time_type    last_time_ff [ptd_pkg::NUM_TASKS];
   ptd_pkg::task_id_type task_id_ff   [ptd_pkg::NUM_TASKS];

   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         last_time_ff[wr.slot] <= wr.last_time;
         if (wr.cfg_en) begin
            period_ff[wr.slot]  <= wr.period;
            task_id_ff[wr.slot] <= wr.task_id;
         end
         if (wr.enable_en) begin
            enable_ff[wr.slot] <= wr.enable;
         end
      end
   end

   always_comb begin
      rd.period    = period_ff[rd_slot];
      rd.enable    = enable_ff[rd_slot];
      rd.last_time = last_time_ff[rd_slot];
      rd.task_id   = task_id_ff[rd_slot];
   end

endmodule

@@ sv/ptd_id_map.sv @@
module ptd_id_map (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  ptd_pkg::task_id_type wr_id,
   input  ptd_pkg::count_type   wr_value,
   input  ptd_pkg::task_id_type rd_id,
   output ptd_pkg::count_type   rd_value
);

   // zero = unregistered, otherwise slot + 1
   ptd_pkg::count_type map_ff [ptd_pkg::ID_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ptd_pkg::ID_COUNT; i++) begin
            map_ff[i] <= '0;
         end
      end else if (wr_en) begin
         map_ff[wr_id] <= wr_value;
      end
   end

   assign rd_value = map_ff[rd_id];

endmodule

@@ sv/periodic_task_dispatcher.sv @@
// The start transfer is registered in req_valid_ff, then in rsp_valid_ff, which drives rsp_valid.
// Throughput: one item per cycle; busy is always low. The bound is the
// combinational slot check (32-bit subtract and compare) in the execute stage.
// Reset clears the id map, slot count, poll pointer and both valid flags.
// The receiver cannot stall: each result is shown for exactly one cycle.
module periodic_task_dispatcher (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_operation,
   input  ptd_pkg::task_id_type req_task_id,
   input  ptd_pkg::time_type    req_period,
   input  logic                 req_enable,
   input  ptd_pkg::time_type    req_now,
   output logic                 rsp_valid,
   output logic                 rsp_fired,
   output ptd_pkg::task_id_type rsp_fired_task_id,
   output logic [1:0]           rsp_status
);

   logic                 req_valid_ff;
   logic [1:0]           req_operation_ff;
   ptd_pkg::task_id_type req_task_id_ff;
   ptd_pkg::time_type    req_period_ff;
   logic                 req_enable_ff;
   ptd_pkg::time_type    req_now_ff;

   ptd_pkg::count_type   slot_count_ff, slot_count_in;
   ptd_pkg::slot_type    poll_slot_ff, poll_slot_in;

   logic                 rsp_valid_ff;
   logic                 rsp_fired_ff, rsp_fired_in;
   ptd_pkg::task_id_type rsp_fired_task_id_ff, rsp_fired_task_id_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;

   ptd_pkg::slot_write_type tbl_wr;
   ptd_pkg::slot_read_type  tbl_rd;
   ptd_pkg::slot_type       cur_slot;
   ptd_pkg::count_type      next_slot;
   ptd_pkg::count_type      map_rd;
   logic                    map_wr_en;
   ptd_pkg::time_type       elapsed;

   assign busy = 1'b0;

   ptd_slot_table u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd_slot (cur_slot),
      .rd      (tbl_rd)
   );

   ptd_id_map u_map (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (map_wr_en),
      .wr_id    (req_task_id_ff),
      .wr_value (ptd_pkg::count_type'(slot_count_ff + 1'b1)),
      .rd_id    (req_task_id_ff),
      .rd_value (map_rd)
   );

   always_comb begin
      // poll pointer past the end wraps to slot 0
      if (ptd_pkg::count_type'(poll_slot_ff) >= slot_count_ff) begin
         cur_slot = '0;
      end else begin
         cur_slot = poll_slot_ff;
      end
      next_slot = ptd_pkg::count_type'(cur_slot) + 1'b1;
      elapsed   = req_now_ff - tbl_rd.last_time;

      tbl_wr               = '0;
      map_wr_en            = 1'b0;
      slot_count_in        = slot_count_ff;
      poll_slot_in         = poll_slot_ff;
      rsp_fired_in         = 1'b0;
      rsp_fired_task_id_in = '0;
      rsp_status_in        = ptd_pkg::STATUS_OK;

      if (req_valid_ff) begin
         case (req_operation_ff)
            ptd_pkg::OP_POLL: begin
               if (slot_count_ff != '0) begin
                  if (tbl_rd.enable && (elapsed >= tbl_rd.period)) begin
                     tbl_wr.wr_en         = 1'b1;
                     tbl_wr.slot          = cur_slot;
                     tbl_wr.last_time     = tbl_rd.last_time + tbl_rd.period;
                     rsp_fired_in         = 1'b1;
                     rsp_fired_task_id_in = tbl_rd.task_id;
                  end
                  if (next_slot >= slot_count_ff) begin
                     poll_slot_in = '0;
                  end else begin
                     poll_slot_in = next_slot[ptd_pkg::SLOT_W-1:0];
                  end
               end
            end
            ptd_pkg::OP_ADD: begin
               if (slot_count_ff == ptd_pkg::count_type'(ptd_pkg::NUM_TASKS)) begin
                  rsp_status_in = ptd_pkg::STATUS_FULL;
               end else begin
                  tbl_wr.wr_en     = 1'b1;
                  tbl_wr.slot      = slot_count_ff[ptd_pkg::SLOT_W-1:0];
                  tbl_wr.cfg_en    = 1'b1;
                  tbl_wr.period    = req_period_ff;
                  tbl_wr.task_id   = req_task_id_ff;
                  tbl_wr.enable_en = 1'b1;
                  tbl_wr.enable    = req_enable_ff;
                  tbl_wr.last_time = '0;
                  map_wr_en        = 1'b1;
                  slot_count_in    = ptd_pkg::count_type'(slot_count_ff + 1'b1);
               end
            end
            ptd_pkg::OP_SET_ENABLE: begin
               if ((map_rd == '0) || (map_rd > slot_count_ff)) begin
                  rsp_status_in = ptd_pkg::STATUS_UNKNOWN;
               end else begin
                  tbl_wr.wr_en     = 1'b1;
                  tbl_wr.slot      = ptd_pkg::slot_type'(map_rd - 1'b1);
                  tbl_wr.enable_en = 1'b1;
                  tbl_wr.enable    = req_enable_ff;
                  tbl_wr.last_time = req_now_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         slot_count_ff <= '0;
         poll_slot_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         req_valid_ff  <= start && !busy;
         slot_count_ff <= slot_count_in;
         poll_slot_ff  <= poll_slot_in;
         rsp_valid_ff  <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_operation_ff <= req_operation;
         req_task_id_ff   <= req_task_id;
         req_period_ff    <= req_period;
         req_enable_ff    <= req_enable;
         req_now_ff       <= req_now;
      end
      rsp_fired_ff         <= rsp_fired_in;
      rsp_fired_task_id_ff <= rsp_fired_task_id_in;
      rsp_status_ff        <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fired         = rsp_fired_ff;
   assign rsp_fired_task_id = rsp_fired_task_id_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

@@ sv/ptd_checker.sv @@
`include "periodic_task_dispatcher_assert.svh"

module ptd_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic                 rsp_fired,
   input ptd_pkg::task_id_type rsp_fired_task_id,
   input logic [1:0]           rsp_status
);

   // every accepted item yields exactly one strobe, and no strobe comes without one
   `PTD_ASSERT_NEXT(a_accept_strobe, clock, reset, start && !busy, ##1 rsp_valid)
   `PTD_ASSERT_NEXT(a_no_spurious, clock, reset, !(start && !busy), ##1 !rsp_valid)
   `PTD_ASSERT_SAME(a_idle_id, clock, reset, rsp_valid && !rsp_fired, rsp_fired_task_id == '0)
   `PTD_ASSERT_SAME(a_fire_ok, clock, reset, rsp_valid && rsp_fired,
                    rsp_status == ptd_pkg::STATUS_OK)

endmodule

bind periodic_task_dispatcher ptd_checker u_ptd_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_fired         (rsp_fired),
   .rsp_fired_task_id (rsp_fired_task_id),
   .rsp_status        (rsp_status)
);

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import ptd_pkg::*;

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int         RANDOM_ITEMS = 600;
   localparam int         STALL_LIMIT  = 2000;

   typedef struct packed {
      logic        fired;
      task_id_type fired_id;
      logic [1:0]  status;
   } dispatch_outcome_type;

   // Mirror of the slot table; predicts one outcome per accepted command.
   class dispatch_predictor;
      time_type             slot_per[NUM_TASKS];
      logic                 slot_en[NUM_TASKS];
      time_type             slot_last[NUM_TASKS];
      task_id_type          slot_tid[NUM_TASKS];
      count_type            id_map[ID_COUNT];   // 0 = unregistered, else slot + 1
      count_type            used_slots;
      slot_type             poll_ptr;
      dispatch_outcome_type pending[$];
      int                   failures;

      function new();
         for (int i = 0; i < NUM_TASKS; i++) begin
            slot_per[i]  = '0;
            slot_en[i]   = 1'b0;
            slot_last[i] = '0;
            slot_tid[i]  = '0;
         end
         for (int i = 0; i < ID_COUNT; i++) id_map[i] = '0;
         used_slots = '0;
         poll_ptr   = '0;
         failures   = 0;
      endfunction

      function void note_command(logic [1:0] op, task_id_type id, time_type per,
                                 logic en, time_type now);
         dispatch_outcome_type r;
         slot_type             s;
         count_type            nxt;
         count_type            m;
         r = '0;
         case (op)
            OP_POLL: if (used_slots != 0) begin
               s = (count_type'(poll_ptr) >= used_slots) ? slot_type'(0) : poll_ptr;
               if (slot_en[s] && time_type'(now - slot_last[s]) >= slot_per[s]) begin
                  slot_last[s] = slot_last[s] + slot_per[s];
                  r.fired      = 1'b1;
                  r.fired_id   = slot_tid[s];
               end
               nxt      = count_type'(s) + count_type'(1);
               poll_ptr = (nxt >= used_slots) ? slot_type'(0) : slot_type'(nxt);
            end
            OP_ADD: if (used_slots >= NUM_TASKS) begin
               r.status = STATUS_FULL;
            end else begin
               s            = slot_type'(used_slots);
               slot_per[s]  = per;
               slot_en[s]   = en;
               slot_last[s] = '0;
               slot_tid[s]  = id;
               id_map[id]   = used_slots + count_type'(1);
               used_slots   = used_slots + count_type'(1);
            end
            OP_SET_ENABLE: begin
               m = id_map[id];
               if (m == 0 || m > used_slots) begin
                  r.status = STATUS_UNKNOWN;
               end else begin
                  slot_en[slot_type'(m - 1)]   = en;
                  slot_last[slot_type'(m - 1)] = now;
               end
            end
            default: ;
         endcase
         pending.push_back(r);
      endfunction

      function void check_dispatch(logic fired, task_id_type fired_id, logic [1:0] status);
         dispatch_outcome_type e;
         if (pending.size() == 0) begin
            $error("result with none pending: fired=%0d fired_task_id=%0d status=%0d",
                   fired, fired_id, status);
            failures++;
            return;
         end
         e = pending.pop_front();
         if (fired !== e.fired) begin
            $error("fired: expected %0d, actual %0d", e.fired, fired);
            failures++;
         end
         if (fired_id !== e.fired_id) begin
            $error("fired_task_id: expected %0d, actual %0d", e.fired_id, fired_id);
            failures++;
         end
         if (status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, status);
            failures++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_operation;
   task_id_type req_task_id;
   time_type    req_period;
   logic        req_enable;
   time_type    req_now;
   logic        rsp_valid;
   logic        rsp_fired;
   task_id_type rsp_fired_task_id;
   logic [1:0]  rsp_status;

   dispatch_predictor book;
   time_type          now_ms;
   bit                idling_on;
   int                quiet_cycles;

   periodic_task_dispatcher dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_task_id       (req_task_id),
      .req_period        (req_period),
      .req_enable        (req_enable),
      .req_now           (req_now),
      .rsp_valid         (rsp_valid),
      .rsp_fired         (rsp_fired),
      .rsp_fired_task_id (rsp_fired_task_id),
      .rsp_status        (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // note before check so a short latency still finds its expectation
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            book.note_command(req_operation, req_task_id, req_period, req_enable, req_now);
         if (rsp_valid)
            book.check_dispatch(rsp_fired, rsp_fired_task_id, rsp_status);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Entered and left at a rising edge; returns at the edge of the transfer.
   task send_command(input logic [1:0] op, input task_id_type id, input time_type per,
                     input logic en, input time_type now);
      // each cycle idles with the same odds
      while (idling_on && $urandom_range(0, 99) < 29) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_task_id   <= id;
      req_period    <= per;
      req_enable    <= en;
      req_now       <= now;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task drain_all();
      start <= 1'b0;
      @(posedge clock);
      while (book.pending.size() != 0) @(posedge clock);
   endtask

   function time_type pick_period();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 22) return $urandom;
      return $urandom_range(1, 40);
   endfunction

   function void bump_now();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) now_ms = $urandom;
      else now_ms = now_ms + time_type'($urandom_range(0, 15));
   endfunction

   task random_command();
      int         r;
      logic [1:0] op;
      r = $urandom_range(0, 99);
      if (r < 68) op = OP_POLL;
      else if (r < 80) op = OP_ADD;
      else if (r < 96) op = OP_SET_ENABLE;
      else op = OP_UNUSED;
      bump_now();
      send_command(op, task_id_type'($urandom_range(0, 15)), pick_period(),
                   logic'($urandom_range(0, 99) < 80), now_ms);
   endtask

   initial begin
      book          = new();
      idling_on     = 1'b1;
      now_ms        = '0;
      reset         <= 1'b1;
      start         <= 1'b0;
      req_operation <= OP_POLL;
      req_task_id   <= '0;
      req_period    <= '0;
      req_enable    <= 1'b0;
      req_now       <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty table, unknown id, unused code with every bit set
      send_command(OP_POLL, 4'd0, '0, 1'b0, '0);
      send_command(OP_SET_ENABLE, 4'd5, '0, 1'b1, 32'd7);
      send_command(OP_UNUSED, 4'hF, '1, 1'b1, '1);
      // zero period, largest period, disabled task
      send_command(OP_ADD, 4'd15, '0, 1'b1, '0);
      send_command(OP_ADD, 4'd0, '1, 1'b1, '0);
      send_command(OP_ADD, 4'd3, 32'd10, 1'b0, '0);
      repeat (3) send_command(OP_POLL, 4'd0, '0, 1'b0, 32'd50);
      send_command(OP_SET_ENABLE, 4'd3, '0, 1'b1, 32'd100);
      // same id again: new slot, old one keeps running
      send_command(OP_ADD, 4'd3, 32'd5, 1'b1, '0);
      repeat (4) send_command(OP_POLL, 4'd0, '0, 1'b0, 32'd112);
      // elapsed time across the 32-bit wrap
      send_command(OP_SET_ENABLE, 4'd15, '0, 1'b1, 32'hFFFF_FFFE);
      send_command(OP_POLL, 4'd0, '0, 1'b0, 32'd5);
      send_command(OP_SET_ENABLE, 4'd3, '0, 1'b0, 32'd200);
      send_command(OP_ADD, 4'd9, 32'h8000_0000, 1'b0, 32'd200);
      now_ms = 32'd200;
      drain_all();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         idling_on = !(i >= 200 && i < 320);
         if (i > 0 && $urandom_range(0, 99) == 0) drain_all();
         random_command();
      end
      start <= 1'b0;

      while (book.pending.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (book.failures == 0 && book.pending.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
